/* rtl/prime_sieve_up_to_limit_unit_defines.svh */
// Assertion macros for the prime sieve unit
`ifndef PRIME_SIEVE_UP_TO_LIMIT_UNIT_DEFINES_SVH
`define PRIME_SIEVE_UP_TO_LIMIT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/psieve_pkg.sv */
// Shared constants, types and helpers of the prime sieve unit
`timescale 1ns / 1ps

package psieve_pkg;

	localparam int MAX_N     = 256;
	localparam int NUM_W     = 9;
	localparam int SUM_W     = NUM_W + 1;
	localparam int MAP_DEPTH = MAX_N + 1;
	localparam int ADDR_W    = $clog2(MAP_DEPTH);

	localparam logic [NUM_W-1:0] MIN_LIMIT = NUM_W'(2);
	localparam logic [NUM_W-1:0] MAX_LIMIT = NUM_W'(MAX_N);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic              wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_ctrl_t;

	typedef struct packed {
		logic             load;
		logic [NUM_W-1:0] prime;
		logic             last;
	} out_load_t;

	typedef struct packed {
		logic [NUM_W-1:0] lim;
		logic             pend_val;
	} seq_stat_t;

	function automatic logic [NUM_W-1:0] hold_limit(input logic [NUM_W-1:0] raw);
		logic [NUM_W-1:0] res;
		res = raw;
		if (raw < MIN_LIMIT) begin
			res = MIN_LIMIT;
		end else if (raw > MAX_LIMIT) begin
			res = MAX_LIMIT;
		end
		return res;
	endfunction

endpackage

/* rtl/psieve_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module psieve_ram #(
	parameter int WIDTH  = 1,
	parameter int DEPTH  = 257,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/psieve_add.sv */
// Shared adder and limit compare of the sieve sequencer
`timescale 1ns / 1ps

module psieve_add (
	input  logic [psieve_pkg::NUM_W-1:0] op_a,
	input  logic [psieve_pkg::NUM_W-1:0] op_b,
	input  logic [psieve_pkg::NUM_W-1:0] lim,
	output logic [psieve_pkg::SUM_W-1:0] sum,
	output logic                         le
);

	assign sum = psieve_pkg::SUM_W'(op_a) + psieve_pkg::SUM_W'(op_b);
	assign le  = sum <= psieve_pkg::SUM_W'(lim);

endmodule

/* rtl/psieve_seq.sv */
// Sequencer: clear, mark multiples and scan the composite map
`timescale 1ns / 1ps

module psieve_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psieve_pkg::NUM_W-1:0]  limit,
	input  logic                          out_free,
	input  logic                          rd_data,
	output logic                          idle,
	output psieve_pkg::ram_ctrl_t         ram_ctrl,
	output psieve_pkg::out_load_t         out_load,
	output psieve_pkg::seq_stat_t         stat
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CLEAR  = 9'b000000010,
		ST_S_RD   = 9'b000000100,
		ST_S_CHK  = 9'b000001000,
		ST_S_MARK = 9'b000010000,
		ST_S_ADV  = 9'b000100000,
		ST_P_RD   = 9'b001000000,
		ST_P_CHK  = 9'b010000000,
		ST_FLUSH  = 9'b100000000
	} state_t;

	state_t                        state_q;
	logic [psieve_pkg::NUM_W-1:0]  lim_q;
	logic [psieve_pkg::NUM_W-1:0]  n_q;
	logic [psieve_pkg::NUM_W-1:0]  m_q;
	logic [psieve_pkg::NUM_W-1:0]  pend_q;
	logic                          pend_val_q;

	logic [psieve_pkg::NUM_W-1:0]  op_a;
	logic [psieve_pkg::NUM_W-1:0]  op_b;
	logic [psieve_pkg::SUM_W-1:0]  sum;
	logic [psieve_pkg::NUM_W-1:0]  sum_n;
	logic                          le;
	logic                          is_prime;

	assign is_prime = !rd_data;
	assign op_a     = (state_q == ST_S_MARK) ? m_q : n_q;
	assign op_b     = ((state_q == ST_S_MARK) || ((state_q == ST_S_CHK) && is_prime)) ?
		n_q : psieve_pkg::NUM_W'(1);
	assign sum_n    = sum[psieve_pkg::NUM_W-1:0];

	psieve_add u_add (
		.op_a (op_a),
		.op_b (op_b),
		.lim  (lim_q),
		.sum  (sum),
		.le   (le)
	);

	assign idle = (state_q == ST_IDLE);

	always_comb begin
		ram_ctrl.we    = state_q inside {ST_CLEAR, ST_S_MARK};
		ram_ctrl.waddr = (state_q == ST_CLEAR) ? n_q[psieve_pkg::ADDR_W-1:0]
			: m_q[psieve_pkg::ADDR_W-1:0];
		ram_ctrl.wdata = (state_q == ST_S_MARK);
		ram_ctrl.raddr = n_q[psieve_pkg::ADDR_W-1:0];
	end

	always_comb begin
		out_load.load  = ((state_q == ST_P_CHK) && is_prime && pend_val_q && out_free)
			|| ((state_q == ST_FLUSH) && out_free);
		out_load.prime = pend_q;
		out_load.last  = (state_q == ST_FLUSH);
	end

	assign stat.lim      = lim_q;
	assign stat.pend_val = pend_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_val_q <= 1'b0;
			lim_q      <= psieve_pkg::MIN_LIMIT;
			n_q        <= '0;
			m_q        <= '0;
			pend_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						lim_q   <= psieve_pkg::hold_limit(limit);
						n_q     <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (le) begin
						n_q <= sum_n;
					end else begin
						n_q     <= psieve_pkg::MIN_LIMIT;
						state_q <= ST_S_RD;
					end
				end
				ST_S_RD: begin
					state_q <= ST_S_CHK;
				end
				ST_S_CHK: begin
					if (is_prime) begin
						if (le) begin
							m_q     <= sum_n;
							state_q <= ST_S_MARK;
						end else begin
							// no multiple of this or any larger number fits
							n_q     <= psieve_pkg::MIN_LIMIT;
							state_q <= ST_P_RD;
						end
					end else if (le) begin
						n_q     <= sum_n;
						state_q <= ST_S_RD;
					end else begin
						n_q     <= psieve_pkg::MIN_LIMIT;
						state_q <= ST_P_RD;
					end
				end
				ST_S_MARK: begin
					if (le) begin
						m_q <= sum_n;
					end else begin
						state_q <= ST_S_ADV;
					end
				end
				ST_S_ADV: begin
					if (le) begin
						n_q     <= sum_n;
						state_q <= ST_S_RD;
					end else begin
						n_q     <= psieve_pkg::MIN_LIMIT;
						state_q <= ST_P_RD;
					end
				end
				ST_P_RD: begin
					state_q <= ST_P_CHK;
				end
				ST_P_CHK: begin
					if (!(is_prime && pend_val_q && !out_free)) begin
						if (is_prime) begin
							pend_q     <= n_q;
							pend_val_q <= 1'b1;
						end
						if (le) begin
							n_q     <= sum_n;
							state_q <= ST_P_RD;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_val_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/prime_sieve_up_to_limit_unit.sv */
// Top level of the prime sieve unit: map RAM, sequencer and output register
//
// Takes one limit word at a time (held to 2..MAX_N) and returns every prime
// up to it in ascending order, one word each, with last set on the largest.
// limit_ready is high only while the unit is idle. A request runs through the
// composite map: it clears it, tests each number during sieving up to the
// first prime whose double passes the limit, marks each multiple of each
// prime and advances after each prime, then scans each number and flushes the
// largest prime. The result register lets the sieve keep scanning while a
// finished word waits, up to the next prime that it finds.
`timescale 1ns / 1ps
`include "prime_sieve_up_to_limit_unit_defines.svh"

module prime_sieve_up_to_limit_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          limit_valid,
	output logic                          limit_ready,
	input  logic [psieve_pkg::NUM_W-1:0]  limit,
	output logic                          prime_valid,
	input  logic                          prime_ready,
	output logic [psieve_pkg::NUM_W-1:0]  prime,
	output logic                          last
);

	psieve_pkg::ram_ctrl_t         ram_ctrl;
	psieve_pkg::out_load_t         out_load;
	psieve_pkg::seq_stat_t         stat;
	logic                          rd_data;
	logic                          idle;
	logic                          out_free;
	logic                          prime_valid_q;
	logic [psieve_pkg::NUM_W-1:0]  prime_q;
	logic                          last_q;

	assign out_free    = !prime_valid_q || prime_ready;
	assign limit_ready = idle;

	psieve_ram #(
		.WIDTH (1),
		.DEPTH (psieve_pkg::MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_ctrl.we),
		.waddr (ram_ctrl.waddr),
		.wdata (ram_ctrl.wdata),
		.raddr (ram_ctrl.raddr),
		.rdata (rd_data)
	);

	psieve_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (limit_valid && idle),
		.limit    (limit),
		.out_free (out_free),
		.rd_data  (rd_data),
		.idle     (idle),
		.ram_ctrl (ram_ctrl),
		.out_load (out_load),
		.stat     (stat)
	);

	// hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_valid_q <= 1'b0;
		end else if (out_load.load) begin
			prime_valid_q <= 1'b1;
		end else if (prime_ready) begin
			prime_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load.load) begin
			prime_q <= out_load.prime;
			last_q  <= out_load.last;
		end
	end

	assign prime_valid = prime_valid_q;
	assign prime       = prime_q;
	assign last        = last_q;

	`PS_ASSERT_NOW(a_load_free, out_load.load, out_free, "word loaded over a waiting word")
	`PS_ASSERT_NOW(a_idle_clean, idle, !stat.pend_val, "pending prime left when idle")
	`PS_ASSERT_NOW(a_prime_range, out_load.load,
		(out_load.prime >= psieve_pkg::MIN_LIMIT) && (out_load.prime <= stat.lim),
		"prime outside held limit")
	`PS_ASSERT_NEXT(a_busy_after_start, limit_valid && limit_ready, !limit_ready,
		"ready after accepting a limit")

endmodule

/* sim/prime_sieve_up_to_limit_unit_test.sv */
// Testbench for the prime sieve unit: random limits, sieve scoreboard, ready/valid stalls
`timescale 1ns / 1ps

module prime_sieve_up_to_limit_unit_test;

	localparam int HOLD_CYCLES    = 3000;
	localparam int WATCHDOG_LIMIT = 30000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int PHASE_ITEMS    = 60;

	class prime_scoreboard;
		typedef struct packed {
			logic [psieve_pkg::NUM_W-1:0] prime;
			logic                         last;
		} prime_word_t;

		prime_word_t primes_due[$];
		int          errors = 0;

		task report(input string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void note_limit(input logic [psieve_pkg::NUM_W-1:0] raw);
			bit          composite [0:psieve_pkg::MAX_N];
			int          lim;
			int          top_prime;
			prime_word_t w;
			lim = int'(raw);
			if (raw < psieve_pkg::MIN_LIMIT) begin
				lim = int'(psieve_pkg::MIN_LIMIT);
			end else if (raw > psieve_pkg::MAX_LIMIT) begin
				lim = int'(psieve_pkg::MAX_LIMIT);
			end
			foreach (composite[i]) composite[i] = 1'b0;
			for (int n = 2; n <= lim; n++) begin
				if (!composite[n]) begin
					for (int m = n + n; m <= lim; m += n) composite[m] = 1'b1;
				end
			end
			top_prime = 2;
			for (int n = 2; n <= lim; n++) begin
				if (!composite[n]) top_prime = n;
			end
			for (int n = 2; n <= lim; n++) begin
				if (!composite[n]) begin
					w.prime = psieve_pkg::NUM_W'(n);
					w.last  = (n == top_prime);
					primes_due.push_back(w);
				end
			end
		endfunction

		task check_prime(input logic [psieve_pkg::NUM_W-1:0] prime, input logic last);
			prime_word_t w;
			if (primes_due.size() == 0) begin
				report($sformatf("unexpected word prime=%0d last=%0b", prime, last));
			end else begin
				w = primes_due.pop_front();
				if (prime !== w.prime) begin
					report($sformatf("prime got %0d want %0d", prime, w.prime));
				end
				if (last !== w.last) begin
					report($sformatf("last got %0b want %0b (prime %0d)", last, w.last,
						w.prime));
				end
			end
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         limit_valid;
	logic                         limit_ready;
	logic [psieve_pkg::NUM_W-1:0] limit;
	logic                         prime_valid;
	logic                         prime_ready;
	logic [psieve_pkg::NUM_W-1:0] prime;
	logic                         last;

	prime_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_grants   = 0;
	int quiet_cycles  = 0;

	int directed_limits [23] = '{0, 1, 2, 3, 4, 5, 6, 7, 11, 13, 16, 17, 31, 32, 63, 64,
		127, 128, 255, 256, 257, 300, 511};

	prime_sieve_up_to_limit_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit_valid (limit_valid),
		.limit_ready (limit_ready),
		.limit       (limit),
		.prime_valid (prime_valid),
		.prime_ready (prime_ready),
		.prime       (prime),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [psieve_pkg::NUM_W-1:0] pick_limit();
		int r;
		r = $urandom_range(99);
		if (r < 65) begin
			return psieve_pkg::NUM_W'($urandom_range(40, 0));
		end else if (r < 85) begin
			return psieve_pkg::NUM_W'($urandom_range(psieve_pkg::MAX_N, 41));
		end
		return psieve_pkg::NUM_W'($urandom);
	endfunction

	task automatic send_limit(input logic [psieve_pkg::NUM_W-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			limit_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		limit_valid <= 1'b1;
		limit       <= value;
		do @(posedge clk); while (!limit_ready);
	endtask

	task automatic wait_drained();
		limit_valid <= 1'b0;
		@(posedge clk);
		while (sb.primes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : result_sink
		int hold_left;
		int grants_seen;
		hold_left   = 0;
		grants_seen = 0;
		prime_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_grants != grants_seen) begin
				grants_seen = hold_grants;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				prime_ready <= 1'b0;
			end else begin
				prime_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (limit_valid && limit_ready) sb.note_limit(limit);
			if (prime_valid && prime_ready) sb.check_prime(prime, last);
			if ((limit_valid && limit_ready) || (prime_valid && prime_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		limit_valid = 1'b0;
		limit       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_idle_pct = 55;
		foreach (directed_limits[i]) send_limit(psieve_pkg::NUM_W'(directed_limits[i]));
		for (int i = 0; i < PHASE_ITEMS; i++) send_limit(pick_limit());
		wait_drained();

		send_idle_pct = 55;
		recv_idle_pct = 14;
		for (int i = 0; i < PHASE_ITEMS; i++) send_limit(pick_limit());
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_grants++;
		for (int i = 0; i < 6; i++) send_limit(psieve_pkg::MAX_LIMIT);
		wait_drained();
		for (int i = 0; i < PHASE_ITEMS; i++) send_limit(pick_limit());
		wait_drained();

		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
